// ----- hw/rtl/ppe_pkg.sv -----
// ----------------------------------------------------------------------------
// ppe_pkg: shared types and constants for the particle pool engine
// Pool geometry, request codes, sequencer states and the direction table.
// ----------------------------------------------------------------------------
package ppe_pkg;

    localparam int PoolSize  = 16;
    localparam int SlotW     = 4;   // $clog2(PoolSize)
    localparam int CountW    = 5;

    typedef enum logic [1:0] {
        REQ_EMIT  = 2'd0,
        REQ_BURST = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_SCAN,
        ST_TICK,
        ST_READ,
        ST_COUNT,
        ST_DONE
    } t_state;

    localparam logic CFG_GRAVITY_STEP = 1'b0;
    localparam logic CFG_GRAVITY_MASK = 1'b1;

    // Unit direction table, 4 fraction bits, indexed by particle number mod 8.
    function automatic logic signed [5:0] dir_x(input logic [2:0] k);
        case (k)
            3'd0: dir_x = 6'sd16;
            3'd1: dir_x = -6'sd16;
            3'd4: dir_x = 6'sd11;
            3'd5: dir_x = -6'sd11;
            3'd6: dir_x = 6'sd11;
            3'd7: dir_x = -6'sd11;
            default: dir_x = 6'sd0;
        endcase
    endfunction

    function automatic logic signed [5:0] dir_y(input logic [2:0] k);
        case (k)
            3'd2: dir_y = 6'sd16;
            3'd3: dir_y = -6'sd16;
            3'd4: dir_y = 6'sd11;
            3'd5: dir_y = 6'sd11;
            3'd6: dir_y = -6'sd11;
            3'd7: dir_y = -6'sd11;
            default: dir_y = 6'sd0;
        endcase
    endfunction

endpackage

// ----- hw/rtl/particle_pool_engine.sv -----
// ----------------------------------------------------------------------------
// particle_pool_engine: fixed pool of sixteen particles
// Emit, burst, tick and read requests run on one slot-walking sequencer.
// ----------------------------------------------------------------------------
// Each request walks its states in order: a read captures the addressed slot, an emit scans
// for the first free slot unless its life is zero, a tick updates every live slot, and a burst
// scales and then scans once for each requested particle. The live count then walks all slots.
// One item is in flight at a time; the next input transfer is taken from the cycle after the
// result transfer. Reset (synchronous, active low) clears every life so that all slots are
// free, clears the live count and loads the gravity registers with their defaults of one.
module particle_pool_engine (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_req_type,
    input  logic signed [15:0]    i_pos_x,
    input  logic signed [15:0]    i_pos_y,
    input  logic signed [15:0]    i_vel_x,
    input  logic signed [15:0]    i_vel_y,
    input  logic signed [15:0]    i_speed,
    input  logic [7:0]            i_burst_count,
    input  logic [7:0]            i_life,
    input  logic [7:0]            i_tile,
    input  logic [7:0]            i_palette,
    input  logic [7:0]            i_flags,
    input  logic [3:0]            i_slot_index,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_accepted,
    output logic [4:0]            o_live_count,
    output logic signed [15:0]    o_out_x,
    output logic signed [15:0]    o_out_y,
    output logic signed [15:0]    o_out_vx,
    output logic signed [15:0]    o_out_vy,
    output logic [7:0]            o_out_life,
    output logic [7:0]            o_out_tile,
    output logic [7:0]            o_out_palette,
    output logic [7:0]            o_out_flags,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [15:0]           i_cfg_data
);
    import ppe_pkg::*;

    // Life store is flip-flops, as reset clears it; the rest of each
    // particle lives in plain registers with no reset.
    logic [7:0]  r_life [PoolSize];
    logic [15:0] r_px   [PoolSize];
    logic [15:0] r_py   [PoolSize];
    logic [15:0] r_vx   [PoolSize];
    logic [15:0] r_vy   [PoolSize];
    logic [7:0]  r_tile [PoolSize];
    logic [7:0]  r_pal  [PoolSize];
    logic [7:0]  r_flg  [PoolSize];

    t_state r_state, n_state;
    logic [15:0] r_grav_step;
    logic [7:0]  r_grav_mask;

    // Captured request.
    t_req        r_req;
    logic [15:0] r_ipx, r_ipy, r_ivx, r_ivy, r_speed;
    logic [7:0]  r_cnt, r_ilife, r_itile, r_ipal, r_iflg;
    logic [3:0]  r_islot;

    // Sequencer counters and per-particle working values.
    logic [SlotW:0] r_slot, n_slot;  // one bit wider to hold PoolSize
    logic [7:0]  r_burst_i, n_burst_i;
    logic [7:0]  r_acc, n_acc;
    logic [CountW-1:0] r_live, n_live;
    logic [15:0] r_bvx, r_bvy;
    logic        r_scale_y, n_scale_y;

    logic [SlotW-1:0] slot_idx;
    assign slot_idx = r_slot[SlotW-1:0];

    // Shared scaling multiplier: one axis per cycle.
    logic signed [21:0] mul_p;
    logic [15:0]        mul_q;
    always_comb begin
        mul_p = $signed(r_speed) * (r_scale_y ? dir_y(r_burst_i[2:0])
                                              : dir_x(r_burst_i[2:0]));
        mul_q = mul_p[19:4];
    end

    // Shared adder for tick updates.
    logic        grav_on;
    logic [15:0] tick_vy;
    always_comb begin
        grav_on = (r_flg[slot_idx] & r_grav_mask) != 8'd0;
        tick_vy = grav_on ? r_vy[slot_idx] + r_grav_step : r_vy[slot_idx];
    end

    logic in_xfer, out_xfer, place_now;
    assign o_ready     = (r_state == ST_IDLE) && !o_valid;
    assign in_xfer     = i_valid && o_ready;
    assign out_xfer    = o_valid && i_ready;
    assign o_cfg_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state   = r_state;
        n_slot    = r_slot;
        n_burst_i = r_burst_i;
        n_acc     = r_acc;
        n_live    = r_live;
        n_scale_y = r_scale_y;
        place_now = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_slot    = '0;
                    n_burst_i = '0;
                    n_acc     = '0;
                    n_scale_y = 1'b0;
                    case (t_req'(i_req_type))
                        REQ_EMIT:  n_state = ST_SCAN;
                        REQ_BURST: n_state = ST_SCALE;
                        REQ_TICK:  n_state = ST_TICK;
                        default:   n_state = ST_READ;
                    endcase
                end
            end
            ST_SCALE: begin
                if (r_burst_i == r_cnt) begin
                    n_state = ST_COUNT;
                    n_slot  = '0;
                    n_live  = '0;
                end else if (r_scale_y) begin
                    n_scale_y = 1'b0;
                    n_slot    = '0;
                    n_state   = ST_SCAN;
                end else begin
                    n_scale_y = 1'b1;
                end
            end
            ST_SCAN: begin
                if (r_ilife == 8'd0 || r_slot == (SlotW+1)'(PoolSize)) begin
                    if (r_req == REQ_BURST) begin
                        n_burst_i = r_burst_i + 8'd1;
                        n_state   = ST_SCALE;
                    end else begin
                        n_state = ST_COUNT;
                        n_slot  = '0;
                        n_live  = '0;
                    end
                end else if (r_life[slot_idx] == 8'd0) begin
                    place_now = 1'b1;
                    n_acc     = r_acc + 8'd1;
                    n_slot    = (SlotW+1)'(PoolSize);
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            ST_TICK: begin
                if (r_slot == (SlotW+1)'(PoolSize)) begin
                    n_state = ST_COUNT;
                    n_slot  = '0;
                    n_live  = '0;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            ST_READ: begin
                n_state = ST_COUNT;
                n_slot  = '0;
                n_live  = '0;
            end
            ST_COUNT: begin
                if (r_slot == (SlotW+1)'(PoolSize)) begin
                    n_state = ST_DONE;
                end else begin
                    if (r_life[slot_idx] != 8'd0) begin
                        n_live = r_live + 5'd1;
                    end
                    n_slot = r_slot + 1'b1;
                end
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_grav_step <= 16'd1;
            r_grav_mask <= 8'd1;
            r_live      <= '0;
            o_valid     <= 1'b0;
            for (int k = 0; k < PoolSize; k++) begin
                r_life[k] <= 8'd0;
            end
        end else begin
            r_state <= n_state;
            r_live  <= n_live;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_GRAVITY_STEP) begin
                    r_grav_step <= i_cfg_data;
                end else begin
                    r_grav_mask <= i_cfg_data[7:0];
                end
            end
            if (place_now) begin
                r_life[slot_idx] <= r_ilife;
            end
            if (r_state == ST_TICK && r_slot != (SlotW+1)'(PoolSize)
                    && r_life[slot_idx] != 8'd0) begin
                r_life[slot_idx] <= r_life[slot_idx] - 8'd1;
            end
            if (r_state == ST_DONE) begin
                o_valid <= 1'b1;
            end else if (out_xfer) begin
                o_valid <= 1'b0;
            end
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        r_slot    <= n_slot;
        r_burst_i <= n_burst_i;
        r_acc     <= n_acc;
        r_scale_y <= n_scale_y;
        if (in_xfer) begin
            r_req   <= t_req'(i_req_type);
            r_ipx   <= i_pos_x;
            r_ipy   <= i_pos_y;
            r_ivx   <= i_vel_x;
            r_ivy   <= i_vel_y;
            r_speed <= i_speed;
            r_cnt   <= i_burst_count;
            r_ilife <= i_life;
            r_itile <= i_tile;
            r_ipal  <= i_palette;
            r_iflg  <= i_flags;
            r_islot <= i_slot_index;
        end
        if (r_state == ST_SCALE) begin
            if (r_scale_y) begin
                r_bvy <= mul_q;
            end else begin
                r_bvx <= mul_q;
            end
        end
        if (place_now) begin
            r_px[slot_idx]   <= r_ipx;
            r_py[slot_idx]   <= r_ipy;
            r_vx[slot_idx]   <= (r_req == REQ_BURST) ? r_bvx : r_ivx;
            r_vy[slot_idx]   <= (r_req == REQ_BURST) ? r_bvy : r_ivy;
            r_tile[slot_idx] <= r_itile;
            r_pal[slot_idx]  <= r_ipal;
            r_flg[slot_idx]  <= r_iflg;
        end
        if (r_state == ST_TICK && r_slot != (SlotW+1)'(PoolSize)
                && r_life[slot_idx] != 8'd0) begin
            r_vy[slot_idx] <= tick_vy;
            r_px[slot_idx] <= r_px[slot_idx] + r_vx[slot_idx];
            r_py[slot_idx] <= r_py[slot_idx] + tick_vy;
        end
        // Result register: read fields captured once, counts at the end.
        if (r_state == ST_IDLE && in_xfer) begin
            o_out_x       <= '0;
            o_out_y       <= '0;
            o_out_vx      <= '0;
            o_out_vy      <= '0;
            o_out_life    <= '0;
            o_out_tile    <= '0;
            o_out_palette <= '0;
            o_out_flags   <= '0;
        end
        if (r_state == ST_READ) begin
            o_out_x       <= r_px[r_islot];
            o_out_y       <= r_py[r_islot];
            o_out_vx      <= r_vx[r_islot];
            o_out_vy      <= r_vy[r_islot];
            o_out_life    <= r_life[r_islot];
            o_out_tile    <= r_tile[r_islot];
            o_out_palette <= r_pal[r_islot];
            o_out_flags   <= r_flg[r_islot];
        end
        if (r_state == ST_DONE) begin
            o_accepted   <= r_acc;
            o_live_count <= r_live;
        end
    end

endmodule
